### rtl/core/sha256c_pkg.sv
// ----------------------------------------------------------------------------
// sha256c_pkg
// Shared types, round constants and sigma functions for the SHA-256
// block compressor.
// ----------------------------------------------------------------------------
package sha256c_pkg;

  // input queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_CHAIN   = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned NUM_ROUNDS  = 64;

  localparam logic [2:0] LAST_INDEX  = 3'd7;
  localparam logic [3:0] LAST_MSG    = 4'd15;
  localparam logic [5:0] LAST_ROUND  = 6'd63;

  // operation codes of an input beat
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_MESSAGE = 1'b1
  } op_t;

  typedef logic [WORD_W-1:0] word_t;

  // all eight chaining words, index 0 is word A
  typedef logic [NUM_CHAIN-1:0][WORD_W-1:0] word_vec_t;

  // one classified input beat as it sits in the queue
  typedef struct packed {
    op_t        op;
    word_t      value;
    logic [2:0] index;
  } item_t;

  // hand-off from the round engine to the output stage
  typedef struct packed {
    logic      start;
    word_vec_t words;
  } emit_req_t;

  // round constants
  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // round function sigma on word a
  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // round function sigma on word e
  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // schedule sigma on w[t-15]
  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // schedule sigma on w[t-2]
  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### rtl/core/sha256c_queue.sv
// ----------------------------------------------------------------------------
// sha256c_queue
// Front end: accepts input beats, tags them with their operation and holds
// them in a small in-order queue for the round engine.
// ----------------------------------------------------------------------------
module sha256c_queue #(
  parameter int unsigned DEPTH = sha256c_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                operation,
  input  logic [31:0]         word_value,
  input  logic [2:0]          word_index,
  output logic                q_valid,
  output sha256c_pkg::item_t  q_item,
  input  logic                q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sha256c_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  sha256c_pkg::item_t in_item;

  // classify the incoming beat
  always_comb begin
    in_item.op    = sha256c_pkg::op_t'(operation);
    in_item.value = word_value;
    in_item.index = word_index;
  end

  assign item_stall = (fill == CNT_W'(DEPTH));
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != '0);
  assign q_item     = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/core/sha256c_engine.sv
// ----------------------------------------------------------------------------
// sha256c_engine
// Back end: applies chaining word loads, shifts message words into the
// block buffer and runs the 64 rounds, one round per cycle.
// ----------------------------------------------------------------------------
module sha256c_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  sha256c_pkg::item_t      q_item,
  output logic                    q_pop,
  output sha256c_pkg::emit_req_t  emit_req,
  input  logic                    emit_busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_ROUND,
    S_FINAL
  } state_t;

  state_t                 state;
  sha256c_pkg::word_vec_t chain;
  sha256c_pkg::word_vec_t chain_next;
  logic [3:0]             word_count;
  logic [5:0]             round_idx;

  sha256c_pkg::word_t     sched [sha256c_pkg::BLOCK_WORDS];
  sha256c_pkg::word_t     v     [sha256c_pkg::NUM_CHAIN];
  sha256c_pkg::word_t     kw;

  logic                   take_msg;
  sha256c_pkg::word_t     ch;
  sha256c_pkg::word_t     maj;
  sha256c_pkg::word_t     t1;
  sha256c_pkg::word_t     t2;
  sha256c_pkg::word_t     sched_new;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign take_msg = q_pop && (q_item.op == sha256c_pkg::OP_MESSAGE);

  // round datapath, k + w comes precomputed
  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + sha256c_pkg::big_sigma1(v[4]) + ch + kw;
    t2  = sha256c_pkg::big_sigma0(v[0]) + maj;
    sched_new = sha256c_pkg::small_sigma1(sched[14]) + sched[9]
              + sha256c_pkg::small_sigma0(sched[1]) + sched[0];
  end

  // feed-forward add into the chaining words
  always_comb begin
    for (int i = 0; i < sha256c_pkg::NUM_CHAIN; i++) begin
      chain_next[i] = chain[i] + v[i];
    end
  end

  assign emit_req.start = (state == S_FINAL) && !emit_busy;
  assign emit_req.words = chain_next;

  // sequencer and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chain      <= '0;
      word_count <= '0;
      round_idx  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_item.op == sha256c_pkg::OP_LOAD) begin
              chain[q_item.index] <= q_item.value;
            end else begin
              word_count <= word_count + 4'd1;
              if (word_count == sha256c_pkg::LAST_MSG) begin
                state <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          round_idx <= '0;
          state     <= S_ROUND;
        end
        S_ROUND: begin
          round_idx <= round_idx + 6'd1;
          if (round_idx == sha256c_pkg::LAST_ROUND) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (!emit_busy) begin
            chain <= chain_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // block buffer, working variables and k + w
  always_ff @(posedge clk) begin
    if (take_msg) begin
      for (int i = 0; i < sha256c_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256c_pkg::BLOCK_WORDS - 1] <= q_item.value;
    end else if (state == S_ROUND) begin
      for (int i = 0; i < sha256c_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256c_pkg::BLOCK_WORDS - 1] <= sched_new;
    end

    if (state == S_PREP) begin
      for (int i = 0; i < sha256c_pkg::NUM_CHAIN; i++) begin
        v[i] <= chain[i];
      end
      kw <= sha256c_pkg::ROUND_K[0] + sched[0];
    end else if (state == S_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      kw   <= sha256c_pkg::ROUND_K[round_idx + 6'd1] + sched[1];
    end
  end

endmodule

### rtl/core/sha256c_emit.sv
// ----------------------------------------------------------------------------
// sha256c_emit
// Output stage: captures the eight updated chaining words of a block and
// sends them out one beat at a time, marking the eighth.
// ----------------------------------------------------------------------------
module sha256c_emit (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256c_pkg::emit_req_t  emit_req,
  output logic                    emit_busy,
  output logic                    digest_valid,
  input  logic                    digest_stall,
  output logic [31:0]             digest_word,
  output logic [2:0]              digest_index,
  output logic                    last_word
);

  sha256c_pkg::word_vec_t words;
  logic [2:0]             idx;
  logic                   active;
  logic                   beat_out;

  assign beat_out     = active && !digest_stall;
  assign emit_busy    = active;
  assign digest_valid = active;
  assign digest_word  = words[idx];
  assign digest_index = idx;
  assign last_word    = (idx == sha256c_pkg::LAST_INDEX);

  // beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (emit_req.start) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (beat_out) begin
      idx <= idx + 3'd1;
      if (idx == sha256c_pkg::LAST_INDEX) begin
        active <= 1'b0;
      end
    end
  end

  // result snapshot
  always_ff @(posedge clk) begin
    if (emit_req.start) begin
      words <= emit_req.words;
    end
  end

endmodule

### rtl/core/sha256_block_compressor_unit.sv
// Sequence: an accepted load or message beat is written into the queue, then popped
// and applied by the engine when it is idle; the sixteenth message word starts a setup
// state, the 64 rounds and a final add state that waits while the output stage is busy;
// the first digest beat follows. Throughput is set by the single round unit doing one
// round per cycle; output overlaps the next block.
// Reset clears chaining words, word count, queue and output stage; buffer is not cleared.
// ----------------------------------------------------------------------------
// sha256_block_compressor_unit
// SHA-256 compression function over a stream of 32-bit words: loads set the
// chaining words, every sixteen message words yield eight digest beats.
// ----------------------------------------------------------------------------
module sha256_block_compressor_unit #(
  parameter int unsigned QUEUE_DEPTH = sha256c_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [31:0] word_value,
  input  logic [2:0]  word_index,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        last_word
);

  logic                   q_valid;
  logic                   q_pop;
  sha256c_pkg::item_t     q_item;
  sha256c_pkg::emit_req_t emit_req;
  logic                   emit_busy;

  // front: accept and queue beats
  sha256c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .word_value (word_value),
    .word_index (word_index),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: loads, block buffer and rounds
  sha256c_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .emit_req  (emit_req),
    .emit_busy (emit_busy)
  );

  // digest output stage
  sha256c_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .emit_req     (emit_req),
    .emit_busy    (emit_busy),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .digest_index (digest_index),
    .last_word    (last_word)
  );

`ifndef ASSERT_OFF
  // a new block result never overwrites one still being sent
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    emit_req.start |-> !emit_busy)
    else $error("block result handed over while output stage busy");

  // the engine only pops a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // an accepted beat leaves the queue non-empty
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> q_valid)
    else $error("accepted beat missing from queue");

  // after the eighth digest beat the output is not valid in the next cycle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_stall && last_word |=> !digest_valid)
    else $error("digest beat follows the last word directly");
`endif

endmodule
